[rtl/core/pyr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyr_pkg
// Shared types, register map and constants of the planar YUV to RGB converter.
// ----------------------------------------------------------------------------
package pyr_pkg;

    localparam int SAMPLE_W = 16;   // width of every input sample port
    localparam int PIX_W    = 8;    // width of every output component
    localparam int SHIFT_W  = 4;    // holds sample_bits - 8, at most 8
    localparam int YO_W     = 18;   // luma minus black level, signed
    localparam int DIF_W    = 17;   // chroma minus mid level, signed
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    localparam int DEF_MAX_SAMPLE_BITS = 16;
    localparam int DEF_COEF_FRAC_BITS  = 16;

    localparam int MIN_SAMPLE_BITS = 8;
    localparam int BLACK_LEVEL     = 16;
    localparam int CHROMA_MID      = 128;

    // register index codes, byte address = 4 * index
    localparam logic [1:0] REG_MATRIX = 2'd0;
    localparam logic [1:0] REG_FULL   = 2'd1;
    localparam logic [1:0] REG_BITS   = 2'd2;
    localparam logic [1:0] REG_GRAY   = 2'd3;

    // matrix codes
    localparam logic [1:0] MTX_IDENTITY = 2'd0;
    localparam logic [1:0] MTX_BT601    = 2'd1;
    localparam logic [1:0] MTX_BT709    = 2'd2;
    localparam logic [1:0] MTX_BT2020   = 2'd3;

    localparam logic [4:0] RST_SAMPLE_BITS = 5'd8;

    // Kr and Kb in units of 1e-4, indexed by matrix code
    localparam int unsigned KR_TAB [4] = '{2990, 2990, 2126, 2627};
    localparam int unsigned KB_TAB [4] = '{1140, 1140, 722, 593};

    typedef struct packed {
        logic [1:0] color_matrix;
        logic       full_swing;
        logic [4:0] sample_bits;
        logic       gray_only;
    } t_cfg;

    typedef struct packed {
        logic               gray;
        logic               ident;
        logic [SHIFT_W-1:0] shift;
    } t_mode;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

endpackage

[rtl/core/pyr_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyr_regs
// APB configuration registers: matrix, range, sample depth and gray mode.
// ----------------------------------------------------------------------------
module pyr_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pyr_pkg::ADDR_W-1:0]  paddr,
    input  logic [pyr_pkg::DATA_W-1:0]  pwdata,
    output logic [pyr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output pyr_pkg::t_cfg               o_cfg
);
    import pyr_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_matrix <= MTX_BT601;
            r_cfg.full_swing   <= 1'b0;
            r_cfg.sample_bits  <= RST_SAMPLE_BITS;
            r_cfg.gray_only    <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_MATRIX: r_cfg.color_matrix <= pwdata[1:0];
                REG_FULL:   r_cfg.full_swing   <= pwdata[0];
                REG_BITS:   r_cfg.sample_bits  <= pwdata[4:0];
                REG_GRAY:   r_cfg.gray_only    <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_MATRIX: prdata = DATA_W'(r_cfg.color_matrix);
            REG_FULL:   prdata = DATA_W'(r_cfg.full_swing);
            REG_BITS:   prdata = DATA_W'(r_cfg.sample_bits);
            REG_GRAY:   prdata = DATA_W'(r_cfg.gray_only);
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/pyr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyr_front
// Stage 1: removes black level (video range only) and chroma offset, picks
// the matrix coefficients and works out the identity-mode bytes.
// ----------------------------------------------------------------------------
module pyr_front #(
    parameter int MAX_SAMPLE_BITS = pyr_pkg::DEF_MAX_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS  = pyr_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pyr_pkg::t_cfg                          i_cfg,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [pyr_pkg::SAMPLE_W-1:0]           i_luma,
    input  logic [pyr_pkg::SAMPLE_W-1:0]           i_cb,
    input  logic [pyr_pkg::SAMPLE_W-1:0]           i_cr,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [pyr_pkg::YO_W-1:0]        o_yo,
    output logic signed [pyr_pkg::DIF_W-1:0]       o_dd,
    output logic signed [pyr_pkg::DIF_W-1:0]       o_ee,
    output logic [COEF_FRAC_BITS+1:0]              o_ky,
    output logic [COEF_FRAC_BITS+1:0]              o_crv,
    output logic [COEF_FRAC_BITS+1:0]              o_cbu,
    output logic [COEF_FRAC_BITS+1:0]              o_cgu,
    output logic [COEF_FRAC_BITS+1:0]              o_cgv,
    output pyr_pkg::t_mode                         o_mode,
    output pyr_pkg::t_rgb                          o_ident
);
    import pyr_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam longint unsigned ONE_F   = 64'd1 << COEF_FRAC_BITS;
    localparam longint unsigned KY_VID  = (64'd510 * ONE_F + 64'd219) / 64'd438;
    localparam longint unsigned KY_FULL = (64'd510 * ONE_F + 64'd255) / 64'd510;

    logic [CW-1:0] w_crv_tab [4][2];
    logic [CW-1:0] w_cbu_tab [4][2];
    logic [CW-1:0] w_cgu_tab [4][2];
    logic [CW-1:0] w_cgv_tab [4][2];

    // coefficients per matrix and range, all fixed at elaboration
    for (genvar gm = 0; gm < 4; gm++) begin : g_mtx
        for (genvar gr = 0; gr < 2; gr++) begin : g_rng
            localparam longint unsigned KR = 64'(KR_TAB[gm]);
            localparam longint unsigned KB = 64'(KB_TAB[gm]);
            localparam longint unsigned KG = 64'd10000 - KR - KB;
            localparam longint unsigned RC = (gr != 0) ? 64'd255 : 64'd224;
            localparam longint unsigned D0 = 64'd10000 * RC;
            localparam longint unsigned DG = D0 * KG;
            localparam longint unsigned N_CRV = (64'd510 * (64'd10000 - KR)) << COEF_FRAC_BITS;
            localparam longint unsigned N_CBU = (64'd510 * (64'd10000 - KB)) << COEF_FRAC_BITS;
            localparam longint unsigned N_CGU =
                (64'd510 * KB * (64'd10000 - KB)) << COEF_FRAC_BITS;
            localparam longint unsigned N_CGV =
                (64'd510 * KR * (64'd10000 - KR)) << COEF_FRAC_BITS;
            localparam longint unsigned C_CRV = (64'd2 * N_CRV + D0) / (64'd2 * D0);
            localparam longint unsigned C_CBU = (64'd2 * N_CBU + D0) / (64'd2 * D0);
            localparam longint unsigned C_CGU = (64'd2 * N_CGU + DG) / (64'd2 * DG);
            localparam longint unsigned C_CGV = (64'd2 * N_CGV + DG) / (64'd2 * DG);

            assign w_crv_tab[gm][gr] = CW'(C_CRV);
            assign w_cbu_tab[gm][gr] = CW'(C_CBU);
            assign w_cgu_tab[gm][gr] = CW'(C_CGU);
            assign w_cgv_tab[gm][gr] = CW'(C_CGV);
        end
    end

    function automatic logic [PIX_W-1:0] sat_shift(input logic [SAMPLE_W-1:0] v,
                                                   input logic [SHIFT_W-1:0]  s);
        logic [SAMPLE_W-1:0] t;
        t = v >> s;
        return (|t[SAMPLE_W-1:PIX_W]) ? {PIX_W{1'b1}} : t[PIX_W-1:0];
    endfunction

    logic [SHIFT_W-1:0]       w_shift;
    logic signed [YO_W-1:0]   w_yo;
    logic signed [DIF_W-1:0]  w_dd;
    logic signed [DIF_W-1:0]  w_ee;
    t_mode                    w_mode;
    t_rgb                     w_ident;

    logic                     r_valid;
    logic signed [YO_W-1:0]   r_yo;
    logic signed [DIF_W-1:0]  r_dd;
    logic signed [DIF_W-1:0]  r_ee;
    logic [CW-1:0]            r_ky;
    logic [CW-1:0]            r_crv;
    logic [CW-1:0]            r_cbu;
    logic [CW-1:0]            r_cgu;
    logic [CW-1:0]            r_cgv;
    t_mode                    r_mode;
    t_rgb                     r_ident;

    // depth clamped to 8..MAX_SAMPLE_BITS
    always_comb begin
        if (i_cfg.sample_bits < 5'(MIN_SAMPLE_BITS)) begin
            w_shift = '0;
        end else if (i_cfg.sample_bits > 5'(MAX_SAMPLE_BITS)) begin
            w_shift = SHIFT_W'(MAX_SAMPLE_BITS - MIN_SAMPLE_BITS);
        end else begin
            w_shift = SHIFT_W'(i_cfg.sample_bits - 5'(MIN_SAMPLE_BITS));
        end
    end

    always_comb begin
        w_yo = $signed({2'b00, i_luma});
        if (!i_cfg.full_swing) begin
            w_yo = w_yo - $signed(YO_W'(BLACK_LEVEL) << w_shift);
        end
        w_dd = $signed({1'b0, i_cb}) - $signed(DIF_W'(CHROMA_MID) << w_shift);
        w_ee = $signed({1'b0, i_cr}) - $signed(DIF_W'(CHROMA_MID) << w_shift);

        w_mode.gray  = i_cfg.gray_only;
        w_mode.ident = (i_cfg.color_matrix == MTX_IDENTITY) && !i_cfg.gray_only;
        w_mode.shift = w_shift;

        w_ident.red   = sat_shift(i_cr, w_shift);
        w_ident.green = sat_shift(i_luma, w_shift);
        w_ident.blue  = sat_shift(i_cb, w_shift);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_yo    <= w_yo;
            r_dd    <= w_dd;
            r_ee    <= w_ee;
            r_ky    <= i_cfg.full_swing ? CW'(KY_FULL) : CW'(KY_VID);
            r_crv   <= w_crv_tab[i_cfg.color_matrix][i_cfg.full_swing];
            r_cbu   <= w_cbu_tab[i_cfg.color_matrix][i_cfg.full_swing];
            r_cgu   <= w_cgu_tab[i_cfg.color_matrix][i_cfg.full_swing];
            r_cgv   <= w_cgv_tab[i_cfg.color_matrix][i_cfg.full_swing];
            r_mode  <= w_mode;
            r_ident <= w_ident;
        end
    end

    assign o_valid = r_valid;
    assign o_yo    = r_yo;
    assign o_dd    = r_dd;
    assign o_ee    = r_ee;
    assign o_ky    = r_ky;
    assign o_crv   = r_crv;
    assign o_cbu   = r_cbu;
    assign o_cgu   = r_cgu;
    assign o_cgv   = r_cgv;
    assign o_mode  = r_mode;
    assign o_ident = r_ident;

endmodule

[rtl/core/pyr_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyr_mac
// Stages 2 and 3: five coefficient products, then the three channel sums.
// ----------------------------------------------------------------------------
module pyr_mac #(
    parameter int COEF_FRAC_BITS = pyr_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  logic signed [pyr_pkg::YO_W-1:0]              i_yo,
    input  logic signed [pyr_pkg::DIF_W-1:0]             i_dd,
    input  logic signed [pyr_pkg::DIF_W-1:0]             i_ee,
    input  logic [COEF_FRAC_BITS+1:0]                    i_ky,
    input  logic [COEF_FRAC_BITS+1:0]                    i_crv,
    input  logic [COEF_FRAC_BITS+1:0]                    i_cbu,
    input  logic [COEF_FRAC_BITS+1:0]                    i_cgu,
    input  logic [COEF_FRAC_BITS+1:0]                    i_cgv,
    input  pyr_pkg::t_mode                               i_mode,
    input  pyr_pkg::t_rgb                                i_ident,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output logic signed [pyr_pkg::YO_W+COEF_FRAC_BITS+4:0] o_acc_r,
    output logic signed [pyr_pkg::YO_W+COEF_FRAC_BITS+4:0] o_acc_g,
    output logic signed [pyr_pkg::YO_W+COEF_FRAC_BITS+4:0] o_acc_b,
    output pyr_pkg::t_mode                               o_mode,
    output pyr_pkg::t_rgb                                o_ident
);
    import pyr_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = YO_W + CW + 1;
    localparam int AW = PW + 2;

    logic                  w_ready3;

    logic                  r_v2;
    logic signed [PW-1:0]  r_yp;
    logic signed [PW-1:0]  r_rp;
    logic signed [PW-1:0]  r_gup;
    logic signed [PW-1:0]  r_gvp;
    logic signed [PW-1:0]  r_bp;
    t_mode                 r_mode2;
    t_rgb                  r_ident2;

    logic                  r_v3;
    logic signed [AW-1:0]  r_acc_r;
    logic signed [AW-1:0]  r_acc_g;
    logic signed [AW-1:0]  r_acc_b;
    t_mode                 r_mode3;
    t_rgb                  r_ident3;

    assign w_ready3 = !r_v3 || i_ready;
    assign o_ready  = !r_v2 || w_ready3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (w_ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // coefficients are unsigned, zero extended before the signed multiply
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_yp     <= i_yo * $signed({1'b0, i_ky});
            r_rp     <= i_ee * $signed({1'b0, i_crv});
            r_gup    <= i_dd * $signed({1'b0, i_cgu});
            r_gvp    <= i_ee * $signed({1'b0, i_cgv});
            r_bp     <= i_dd * $signed({1'b0, i_cbu});
            r_mode2  <= i_mode;
            r_ident2 <= i_ident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready3 && r_v2) begin
            if (r_mode2.gray) begin
                r_acc_r <= AW'(r_yp);
                r_acc_g <= AW'(r_yp);
                r_acc_b <= AW'(r_yp);
            end else begin
                r_acc_r <= AW'(r_yp) + AW'(r_rp);
                r_acc_g <= AW'(r_yp) - AW'(r_gup) - AW'(r_gvp);
                r_acc_b <= AW'(r_yp) + AW'(r_bp);
            end
            r_mode3  <= r_mode2;
            r_ident3 <= r_ident2;
        end
    end

    assign o_valid = r_v3;
    assign o_acc_r = r_acc_r;
    assign o_acc_g = r_acc_g;
    assign o_acc_b = r_acc_b;
    assign o_mode  = r_mode3;
    assign o_ident = r_ident3;

    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_mode3.gray |-> (r_acc_r == r_acc_g) && (r_acc_g == r_acc_b))
        else $error("gray beat with unequal channel sums");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_ready |=> r_v3 && $stable(r_acc_r) && $stable(r_acc_g)
                             && $stable(r_acc_b))
        else $error("stalled sum stage changed");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && w_ready3 |=> r_v3)
        else $error("product stage beat lost");

endmodule

[rtl/core/pyr_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyr_out
// Stage 4: rounds half up, drops the fraction and clamps to 0..255, or passes
// the identity bytes, and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module pyr_out #(
    parameter int COEF_FRAC_BITS = pyr_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic signed [pyr_pkg::YO_W+COEF_FRAC_BITS+4:0] i_acc_r,
    input  logic signed [pyr_pkg::YO_W+COEF_FRAC_BITS+4:0] i_acc_g,
    input  logic signed [pyr_pkg::YO_W+COEF_FRAC_BITS+4:0] i_acc_b,
    input  pyr_pkg::t_mode                                i_mode,
    input  pyr_pkg::t_rgb                                 i_ident,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output pyr_pkg::t_rgb                                 o_rgb
);
    import pyr_pkg::*;

    localparam int AW = YO_W + COEF_FRAC_BITS + 5;
    localparam logic [AW:0] HALF = (AW + 1)'(1) << (COEF_FRAC_BITS - 1);

    function automatic logic [PIX_W-1:0] to_byte(input logic signed [AW-1:0] a,
                                                 input logic [SHIFT_W-1:0] s);
        logic [AW:0] sum;
        logic [AW:0] q;
        sum = {1'b0, a} + (HALF << s);
        q   = (sum >> COEF_FRAC_BITS) >> s;
        if (a[AW-1]) begin
            return '0;
        end
        return (|q[AW:PIX_W]) ? {PIX_W{1'b1}} : q[PIX_W-1:0];
    endfunction

    t_rgb r_rgb;
    logic r_valid;
    t_rgb w_rgb;

    always_comb begin
        if (i_mode.ident) begin
            w_rgb = i_ident;
        end else begin
            w_rgb.red   = to_byte(i_acc_r, i_mode.shift);
            w_rgb.green = to_byte(i_acc_g, i_mode.shift);
            w_rgb.blue  = to_byte(i_acc_b, i_mode.shift);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rgb <= w_rgb;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

[rtl/core/planar_yuv_to_rgb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_yuv_to_rgb
// One pixel of luma and two chroma samples in, 8-bit RGB out.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_ready carries luma, cb and cr (8 to 16 bit
// samples, right aligned); output channel o_out_valid / i_out_ready carries
// red, green and blue. A beat moves when valid and ready are both high.
// Four register stages: offsets and coefficient pick, products, channel
// sums, round and clamp into the output register, passed in that order. One
// pixel per clock sustained while i_out_ready is high; the five multiplies
// of stage two set the clock. Each stage is ready when empty or when the
// next one moves, so a stall on i_out_ready fills the bubbles first and then
// holds every beat in place; o_in_ready falls only once all four stages are
// full. Reset empties the pipeline and loads the registers: BT.601, video
// range, 8-bit samples, gray mode off. Registers sit on the APB port at
// 4 * index (matrix, full range, sample bits, gray); the user must write them
// only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module planar_yuv_to_rgb #(
    parameter int MAX_SAMPLE_BITS = pyr_pkg::DEF_MAX_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS  = pyr_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pyr_pkg::ADDR_W-1:0]    paddr,
    input  logic [pyr_pkg::DATA_W-1:0]    pwdata,
    output logic [pyr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pyr_pkg::SAMPLE_W-1:0]  i_luma_sample,
    input  logic [pyr_pkg::SAMPLE_W-1:0]  i_cb_sample,
    input  logic [pyr_pkg::SAMPLE_W-1:0]  i_cr_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pyr_pkg::PIX_W-1:0]     o_red,
    output logic [pyr_pkg::PIX_W-1:0]     o_green,
    output logic [pyr_pkg::PIX_W-1:0]     o_blue
);
    import pyr_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int AW = YO_W + CW + 3;

    t_cfg                    w_cfg;

    logic                    w_f_valid;
    logic                    w_f_ready;
    logic signed [YO_W-1:0]  w_yo;
    logic signed [DIF_W-1:0] w_dd;
    logic signed [DIF_W-1:0] w_ee;
    logic [CW-1:0]           w_ky;
    logic [CW-1:0]           w_crv;
    logic [CW-1:0]           w_cbu;
    logic [CW-1:0]           w_cgu;
    logic [CW-1:0]           w_cgv;
    t_mode                   w_f_mode;
    t_rgb                    w_f_ident;

    logic                    w_m_valid;
    logic                    w_m_ready;
    logic signed [AW-1:0]    w_acc_r;
    logic signed [AW-1:0]    w_acc_g;
    logic signed [AW-1:0]    w_acc_b;
    t_mode                   w_m_mode;
    t_rgb                    w_m_ident;

    t_rgb                    w_rgb;

    pyr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pyr_front #(
        .MAX_SAMPLE_BITS (MAX_SAMPLE_BITS),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_luma  (i_luma_sample),
        .i_cb    (i_cb_sample),
        .i_cr    (i_cr_sample),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_yo    (w_yo),
        .o_dd    (w_dd),
        .o_ee    (w_ee),
        .o_ky    (w_ky),
        .o_crv   (w_crv),
        .o_cbu   (w_cbu),
        .o_cgu   (w_cgu),
        .o_cgv   (w_cgv),
        .o_mode  (w_f_mode),
        .o_ident (w_f_ident)
    );

    pyr_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_yo    (w_yo),
        .i_dd    (w_dd),
        .i_ee    (w_ee),
        .i_ky    (w_ky),
        .i_crv   (w_crv),
        .i_cbu   (w_cbu),
        .i_cgu   (w_cgu),
        .i_cgv   (w_cgv),
        .i_mode  (w_f_mode),
        .i_ident (w_f_ident),
        .o_valid (w_m_valid),
        .i_ready (w_m_ready),
        .o_acc_r (w_acc_r),
        .o_acc_g (w_acc_g),
        .o_acc_b (w_acc_b),
        .o_mode  (w_m_mode),
        .o_ident (w_m_ident)
    );

    pyr_out #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m_valid),
        .o_ready (w_m_ready),
        .i_acc_r (w_acc_r),
        .i_acc_g (w_acc_g),
        .i_acc_b (w_acc_b),
        .i_mode  (w_m_mode),
        .i_ident (w_m_ident),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_rgb   (w_rgb)
    );

    assign o_red   = w_rgb.red;
    assign o_green = w_rgb.green;
    assign o_blue  = w_rgb.blue;

    // an empty output register means every stage can take a beat
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the planar YUV to RGB pixel converter.
// The stimulus queue is loaded one register setting at a time. It starts with
// a short directed set: black and white levels, sample rails, gray mode over
// identity, identity saturation, and bit depths outside 8..16. Random pixels
// follow under several matrix, range and depth settings. A driver feeds the
// input channel and a monitor takes the output channel, each with random
// gaps and no-gap bursts. Each accepted pixel is converted in fixed point
// here, and the monitor compares every output beat in order.
// ----------------------------------------------------------------------------
module testbench;
    import pyr_pkg::*;

    localparam int MAX_BITS  = DEF_MAX_SAMPLE_BITS;
    localparam int FRAC_BITS = DEF_COEF_FRAC_BITS;
    localparam int SIDE_IN   = 0;
    localparam int SIDE_OUT  = 1;

    typedef struct {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
    } t_yuv;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [SAMPLE_W-1:0] i_luma_sample = '0;
    logic [SAMPLE_W-1:0] i_cb_sample = '0;
    logic [SAMPLE_W-1:0] i_cr_sample = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [PIX_W-1:0]    o_red;
    logic [PIX_W-1:0]    o_green;
    logic [PIX_W-1:0]    o_blue;

    t_cfg cfg;
    t_yuv yuv_pending [$];
    t_rgb rgb_due [$];
    t_yuv next_px;
    t_rgb due_px;
    int   pixels_queued = 0;
    int   pixels_taken = 0;
    int   error_count = 0;
    int   send_wait = 0;
    int   recv_wait = 0;
    int   idle_burst [2] = '{0, 0};
    bit   hold_send = 1'b0;

    planar_yuv_to_rgb u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_luma_sample (i_luma_sample),
        .i_cb_sample   (i_cb_sample),
        .i_cr_sample   (i_cr_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // fixed point conversion of one pixel
    // ------------------------------------------------------------------
    function automatic int eff_bits(input logic [4:0] b);
        if (b < MIN_SAMPLE_BITS) return MIN_SAMPLE_BITS;
        if (b > MAX_BITS) return MAX_BITS;
        return b;
    endfunction

    function automatic longint ratio_round(input longint num, input longint den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic logic [PIX_W-1:0] to_pixel(input longint acc, input int sh);
        longint r;
        if (acc < 0) return 8'd0;
        r = (acc + (longint'(1) << (sh - 1))) >>> sh;
        return (r > 255) ? 8'd255 : 8'(r);
    endfunction

    function automatic logic [PIX_W-1:0] sat_pixel(input logic [SAMPLE_W-1:0] v, input int s);
        logic [SAMPLE_W-1:0] r;
        r = v >> s;
        return (r > 255) ? 8'd255 : r[PIX_W-1:0];
    endfunction

    function automatic t_rgb convert_pixel(input t_cfg c, input t_yuv p);
        int     s;
        int     sh;
        longint ly, lcb, lcr, ry, rc, ky, yacc;
        longint kr, kb, kg, crv, cbu, cgu, cgv, dd, ee;
        t_rgb   px;
        s   = eff_bits(c.sample_bits) - MIN_SAMPLE_BITS;
        sh  = FRAC_BITS + s;
        ly  = p.luma;
        lcb = p.cb;
        lcr = p.cr;
        ry  = c.full_swing ? 255 : 219;
        rc  = c.full_swing ? 255 : 224;
        ky  = ratio_round(longint'(255) << FRAC_BITS, ry);
        if (!c.full_swing) ly = ly - (longint'(BLACK_LEVEL) << s);
        yacc = ly * ky;
        if (c.gray_only) begin
            px.red   = to_pixel(yacc, sh);
            px.green = px.red;
            px.blue  = px.red;
        end else if (c.color_matrix == MTX_IDENTITY) begin
            px.red   = sat_pixel(p.cr, s);
            px.green = sat_pixel(p.luma, s);
            px.blue  = sat_pixel(p.cb, s);
        end else begin
            kr  = KR_TAB[c.color_matrix];
            kb  = KB_TAB[c.color_matrix];
            kg  = 10000 - kr - kb;
            crv = ratio_round((2 * (10000 - kr) * 255) << FRAC_BITS, 10000 * rc);
            cbu = ratio_round((2 * (10000 - kb) * 255) << FRAC_BITS, 10000 * rc);
            cgu = ratio_round((2 * kb * (10000 - kb) * 255) << FRAC_BITS, 10000 * kg * rc);
            cgv = ratio_round((2 * kr * (10000 - kr) * 255) << FRAC_BITS, 10000 * kg * rc);
            dd  = lcb - (longint'(CHROMA_MID) << s);
            ee  = lcr - (longint'(CHROMA_MID) << s);
            px.red   = to_pixel(yacc + ee * crv, sh);
            px.green = to_pixel(yacc - dd * cgu - ee * cgv, sh);
            px.blue  = to_pixel(yacc + dd * cbu, sh);
        end
        return px;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // idle cycles before the next beat, with occasional runs of no idling
    function automatic int draw_wait(input int side);
        if (idle_burst[side] > 0) begin
            idle_burst[side]--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            idle_burst[side] = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample(input int bits);
        int top;
        top = (1 << bits) - 1;
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom);
            2:       return 16'd0;
            3:       return 16'(top);
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_pixel(input int y, input int cb, input int cr);
        t_yuv p;
        p.luma = 16'(y);
        p.cb   = 16'(cb);
        p.cr   = 16'(cr);
        yuv_pending.push_back(p);
        pixels_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixels_taken != pixels_queued || rgb_due.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MATRIX: cfg.color_matrix = val[1:0];
            REG_FULL:   cfg.full_swing   = val[0];
            REG_BITS:   cfg.sample_bits  = val;
            REG_GRAY:   cfg.gray_only    = val[0];
            default:    ;
        endcase
    endtask

    task automatic apply_cfg(input logic [1:0] mtx, input logic full,
                             input logic [4:0] bits, input logic gray);
        write_reg(REG_MATRIX, 5'(mtx));
        write_reg(REG_FULL, 5'(full));
        write_reg(REG_BITS, bits);
        write_reg(REG_GRAY, 5'(gray));
        @(negedge i_clk);
    endtask

    task automatic run_random(input int count, input bit with_pause);
        int bits;
        bits = eff_bits(cfg.sample_bits);
        repeat (count) queue_pixel(rand_sample(bits), rand_sample(bits), rand_sample(bits));
        if (with_pause) begin
            // stop feeding midway and let the pipeline run dry
            do @(negedge i_clk); while (pixels_taken < pixels_queued - count / 2);
            hold_send = 1'b1;
            do @(negedge i_clk); while (rgb_due.size() != 0);
            hold_send = 1'b0;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                next_px.luma = i_luma_sample;
                next_px.cb   = i_cb_sample;
                next_px.cr   = i_cr_sample;
                rgb_due.push_back(convert_pixel(cfg, next_px));
                pixels_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (yuv_pending.size() > 0 && !hold_send) begin
                    next_px = yuv_pending.pop_front();
                    i_luma_sample <= next_px.luma;
                    i_cb_sample   <= next_px.cb;
                    i_cr_sample   <= next_px.cr;
                    i_in_valid    <= 1'b1;
                    send_wait = draw_wait(SIDE_IN);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (rgb_due.size() == 0) begin
                    report_error($sformatf("unexpected beat r=%0d g=%0d b=%0d",
                                           o_red, o_green, o_blue));
                end else begin
                    due_px = rgb_due.pop_front();
                    if (o_red !== due_px.red)
                        report_error($sformatf("red %0d, expected %0d", o_red, due_px.red));
                    if (o_green !== due_px.green)
                        report_error($sformatf("green %0d, expected %0d", o_green,
                                               due_px.green));
                    if (o_blue !== due_px.blue)
                        report_error($sformatf("blue %0d, expected %0d", o_blue, due_px.blue));
                end
                recv_wait = draw_wait(SIDE_OUT);
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            i_out_ready <= (recv_wait == 0);
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        logic [4:0] bits_pick;
        cfg.color_matrix = MTX_BT601;
        cfg.full_swing   = 1'b0;
        cfg.sample_bits  = RST_SAMPLE_BITS;
        cfg.gray_only    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: black, white, rails, a saturated red, below black
        queue_pixel(16, 128, 128);
        queue_pixel(235, 128, 128);
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(65535, 65535, 65535);
        queue_pixel(0, 65535, 0);
        queue_pixel(81, 90, 240);
        queue_pixel(15, 128, 128);
        wait_idle();

        // gray mode wins over identity
        apply_cfg(MTX_IDENTITY, 1'b0, 5'd8, 1'b1);
        queue_pixel(200, 10, 250);
        queue_pixel(0, 255, 255);
        queue_pixel(65535, 0, 0);
        wait_idle();

        // identity shifts down and saturates samples above the depth
        apply_cfg(MTX_IDENTITY, 1'b1, 5'd10, 1'b0);
        queue_pixel(1023, 512, 4);
        queue_pixel(65535, 1024, 1020);
        queue_pixel(0, 0, 0);
        wait_idle();

        // depth below 8 acts as 8
        apply_cfg(MTX_BT709, 1'b1, 5'd0, 1'b0);
        queue_pixel(255, 0, 255);
        queue_pixel(128, 128, 128);
        queue_pixel(0, 255, 0);
        wait_idle();

        // depth above the maximum acts as the maximum
        apply_cfg(MTX_BT2020, 1'b0, 5'd31, 1'b0);
        queue_pixel(4096, 32768, 32768);
        queue_pixel(60160, 61440, 4096);
        queue_pixel(65535, 0, 65535);
        queue_pixel(0, 65535, 65535);
        wait_idle();

        for (int p = 0; p < 12; p++) begin
            case (p)
                0: apply_cfg(MTX_BT2020, 1'b1, 5'd16, 1'b0);
                1: apply_cfg(MTX_BT601, 1'b0, 5'd8, 1'b0);
                2: apply_cfg(MTX_BT709, 1'b0, 5'd12, 1'b0);
                3: apply_cfg(MTX_IDENTITY, 1'b1, 5'd16, 1'b0);
                4: apply_cfg(MTX_BT601, 1'b1, 5'd9, 1'b1);
                5: apply_cfg(MTX_BT709, 1'b0, 5'd17, 1'b1);
                default: begin
                    bits_pick = ($urandom_range(0, 3) == 0) ? 5'($urandom)
                                                            : 5'($urandom_range(8, 16));
                    apply_cfg(2'($urandom), 1'($urandom), bits_pick,
                              $urandom_range(0, 4) == 0);
                end
            endcase
            run_random(105, p == 2);
        end

        if (error_count == 0) begin
            $display("PASS planar_yuv_to_rgb");
        end else begin
            $display("FAIL planar_yuv_to_rgb");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("FAIL planar_yuv_to_rgb");
        $finish;
    end

endmodule
